[hdl/avs_pkg.sv]
// ----------------------------------------------------------------------------
// avs_pkg: shared types and constants of the attribute video scanline block
// Store geometry, request codes, the queue entry layout and the pixel
// formatting functions used by the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package avs_pkg;

    // Store geometry
    localparam int STORE_SIZE = 6912;
    localparam int ADDR_W     = 13;
    localparam logic [ADDR_W-1:0] ATTR_BASE = 13'h1800;
    localparam int PIC_LINES  = 192;
    localparam int PIC_CELLS  = 32;

    // Defaults of the top-level parameters
    localparam int DEF_BORDER_LINES = 24;
    localparam int DEF_BORDER_CELLS = 4;

    // Request queue depth, a power of two
    localparam int QUEUE_DEPTH = 2;

    // Opcode field values
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    typedef enum logic {
        CMD_WRITE,
        CMD_RENDER
    } cmd_kind_t;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
        logic              picture;
        logic [7:0]        row;
        logic [2:0]        border;
        logic              flash_on;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RENDER
    } back_state_t;

    function automatic logic [31:0] border_word(input logic [2:0] colour);
        border_word = {8{1'b0, colour}};
    endfunction

    // Attribute: ink in bits 2..0, paper in 5..3, bright in 6, flash in 7.
    function automatic logic [31:0] cell_word(input logic [7:0] bits,
                                              input logic [7:0] attr,
                                              input logic       flash_on);
        logic [3:0]  ink;
        logic [3:0]  paper;
        logic [31:0] word;
        ink   = {attr[6], attr[2:0]};
        paper = attr[6:3];
        if (attr[7] && flash_on)
        begin
            ink   = attr[6:3];
            paper = {attr[6], attr[2:0]};
        end
        word = '0;
        for (int i = 0; i < 8; i++)
        begin
            word[31-4*i -: 4] = bits[7-i] ? ink : paper;
        end
        cell_word = word;
    endfunction

endpackage

`default_nettype wire

[hdl/avs_front.sv]
// ----------------------------------------------------------------------------
// avs_front: request intake and classification
// Accepts requests, keeps the flash counter and turns each request into a
// queue entry with its picture row and flash phase already resolved.
// ----------------------------------------------------------------------------
`default_nettype none

module avs_front
    import avs_pkg::*;
#(
    parameter int BORDER_LINES = DEF_BORDER_LINES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              opcode,
    input  wire logic [ADDR_W-1:0] byte_address,
    input  wire logic [7:0]        byte_value,
    input  wire logic [7:0]        line_number,
    input  wire logic [2:0]        border_colour,
    input  wire logic              q_ready,
    input  wire logic              init_done,
    output logic                   q_push,
    output cmd_t                   q_data
);

    localparam logic [8:0] PIC_FIRST = 9'(BORDER_LINES);
    localparam logic [8:0] PIC_END   = 9'(BORDER_LINES + PIC_LINES);

    logic [4:0] flash_reg;
    logic [4:0] flash_next;
    logic       accept;
    logic [8:0] line_ext;

    assign in_ready = q_ready && init_done;
    assign accept   = in_valid && in_ready;
    assign line_ext = {1'b0, line_number};

    // The counter steps when line 0 is rendered, before that line uses it.
    always_comb
    begin
        flash_next = flash_reg;
        if (accept && opcode == OP_RENDER && line_number == 8'd0)
        begin
            flash_next = flash_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_reg <= '0;
        end
        else
        begin
            flash_reg <= flash_next;
        end
    end

    always_comb
    begin
        q_data.kind     = (opcode == OP_RENDER) ? CMD_RENDER : CMD_WRITE;
        q_data.addr     = byte_address;
        q_data.value    = byte_value;
        q_data.picture  = (line_ext >= PIC_FIRST) && (line_ext < PIC_END);
        q_data.row      = line_number - PIC_FIRST[7:0];
        q_data.border   = border_colour;
        q_data.flash_on = !flash_next[4];
    end

    // Writes beyond the store are dropped here and never reach the queue.
    assign q_push = accept &&
                    (opcode == OP_RENDER || byte_address < ADDR_W'(STORE_SIZE));

endmodule

`default_nettype wire

[hdl/avs_queue.sv]
// ----------------------------------------------------------------------------
// avs_queue: request queue between front end and back end
// A small register FIFO of classified requests.
// ----------------------------------------------------------------------------
`default_nettype none

module avs_queue
    import avs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      push_ready,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/avs_back.sv]
// ----------------------------------------------------------------------------
// avs_back: video store and line renderer
// Holds the video store, clears it after reset, carries out writes and
// renders lines through a two-stage read and format pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module avs_back
    import avs_pkg::*;
#(
    parameter int BORDER_CELLS = DEF_BORDER_CELLS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_data,
    output logic      q_pop,
    output logic      init_done,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [31:0] pixel_group,
    output logic      last_group
);

    localparam int LINE_WORDS = PIC_CELLS + 2 * BORDER_CELLS;
    localparam int K_W        = $clog2(LINE_WORDS + 1);
    localparam logic [K_W-1:0] K_FIRST = K_W'(BORDER_CELLS);
    localparam logic [K_W-1:0] K_END   = K_W'(BORDER_CELLS + PIC_CELLS);
    localparam logic [K_W-1:0] K_LAST  = K_W'(LINE_WORDS - 1);
    localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(STORE_SIZE - 1);

    logic [7:0] mem [STORE_SIZE];

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [ADDR_W-1:0] clear_cnt_reg;
    logic [K_W-1:0]    k_reg;
    logic              picture_reg;
    logic [7:0]        row_reg;
    logic [2:0]        border_reg;
    logic              flash_reg;

    logic              s1_valid_reg;
    logic              s1_cell_reg;
    logic              s1_last_reg;
    logic              s1_flash_reg;
    logic [2:0]        s1_border_reg;
    logic [7:0]        bits_reg;
    logic [7:0]        attr_reg;

    logic              out_valid_reg;
    logic [31:0]       pixel_group_reg;
    logic              last_group_reg;

    logic              adv;
    logic              issue;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              cell_hit;
    logic [K_W-1:0]    k_off;
    logic [4:0]        x;
    logic [ADDR_W-1:0] pix_addr;
    logic [ADDR_W-1:0] attr_addr;

    assign adv = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_cnt_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && q_data.kind == CMD_RENDER)
                begin
                    state_next = ST_RENDER;
                end
            end
            ST_RENDER:
            begin
                if (adv && k_reg == K_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_pop     = 1'b0;
        issue     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = q_data.addr;
        mem_wdata = q_data.value;
        init_done = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                init_done = 1'b0;
                mem_we    = 1'b1;
                mem_waddr = clear_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                q_pop  = q_valid;
                mem_we = q_valid && q_data.kind == CMD_WRITE;
            end
            ST_RENDER:
            begin
                issue = adv;
            end
            default:
            begin
                init_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clear_cnt_reg <= clear_cnt_reg + ADDR_W'(1);
            end
            if (q_pop)
            begin
                k_reg <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + K_W'(1);
            end
            if (adv)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Line parameters captured when a render request leaves the queue
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            picture_reg <= q_data.picture;
            row_reg     <= q_data.row;
            border_reg  <= q_data.border;
            flash_reg   <= q_data.flash_on;
        end
    end

    // Addresses of word k; the bitmap rows are interleaved by thirds.
    assign cell_hit  = picture_reg && (k_reg >= K_FIRST) && (k_reg < K_END);
    assign k_off     = k_reg - K_FIRST;
    assign x         = k_off[4:0];
    assign pix_addr  = {row_reg[7:6], row_reg[2:0], row_reg[5:3], x};
    assign attr_addr = ATTR_BASE + {3'b000, row_reg[7:3], x};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bits_reg      <= mem[pix_addr];
            attr_reg      <= mem[attr_addr];
            s1_cell_reg   <= cell_hit;
            s1_last_reg   <= k_reg == K_LAST;
            s1_flash_reg  <= flash_reg;
            s1_border_reg <= border_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            pixel_group_reg <= s1_cell_reg ?
                               cell_word(bits_reg, attr_reg, s1_flash_reg) :
                               border_word(s1_border_reg);
            last_group_reg  <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_group = pixel_group_reg;
    assign last_group  = last_group_reg;

endmodule

`default_nettype wire

[hdl/attribute_video_scanline.sv]
// ----------------------------------------------------------------------------
// attribute_video_scanline: bitmap and attribute video line renderer
// Stores a 256x192 bitmap with 8x8 colour attributes and renders screen
// lines, border included, as groups of eight 4-bit colour indices.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake           Payload
//  -------  ------------------  ---------------------------------------------
//  in       in_valid/in_ready   opcode, byte_address, byte_value,
//                               line_number, border_colour
//  out      out_valid/out_ready pixel_group, last_group
//
//  A render request produces 32 + 2*BORDER_CELLS groups (40 by default), one
//  per cycle when out_ready stays high; both bytes of a group are read from
//  the store in the same cycle. A render holds the back end while it takes
//  the request from the queue and then issues its groups; the first group
//  appears after the request has passed the queue and the read and format
//  stages. A write request is carried out as it leaves the queue. After reset
//  the store is cleared one byte a cycle, with in_ready low. An output stall
//  freezes the render pipeline; the two-entry queue takes requests till full.
// ----------------------------------------------------------------------------
`default_nettype none

module attribute_video_scanline
    import avs_pkg::*;
#(
    parameter int BORDER_LINES = DEF_BORDER_LINES,
    parameter int BORDER_CELLS = DEF_BORDER_CELLS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              opcode,
    input  wire logic [ADDR_W-1:0] byte_address,
    input  wire logic [7:0]        byte_value,
    input  wire logic [7:0]        line_number,
    input  wire logic [2:0]        border_colour,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [31:0]            pixel_group,
    output logic                   last_group
);

    // Front to queue
    logic q_push;
    logic q_push_ready;
    cmd_t q_push_data;

    // Queue to back
    logic q_pop;
    logic q_pop_valid;
    cmd_t q_pop_data;

    // The back end reports when the store clearing pass has finished.
    logic init_done;

    // The front end resolves the picture row and the flash phase in request
    // order, so the back end never needs the flash counter.
    avs_front #(
        .BORDER_LINES (BORDER_LINES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .byte_address  (byte_address),
        .byte_value    (byte_value),
        .line_number   (line_number),
        .border_colour (border_colour),
        .q_ready       (q_push_ready),
        .init_done     (init_done),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    avs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_pop_valid),
        .pop_data   (q_pop_data)
    );

    // Writes and renders leave the queue in order, so a write issued after a
    // render can never change bytes the render has already read.
    avs_back #(
        .BORDER_CELLS (BORDER_CELLS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_pop_valid),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .init_done   (init_done),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_group (pixel_group),
        .last_group  (last_group)
    );

endmodule

`default_nettype wire

[tb/tb_attribute_video_scanline.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_attribute_video_scanline: self-checking bench of the scanline renderer
// A queue of write and render requests feeds a clocked driver. The driver
// predicts the pixel groups of every accepted request from a shadow copy of
// the video store and the flash counter. A clocked monitor compares every
// delivered group with the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_attribute_video_scanline;

    import avs_pkg::*;

    localparam int BORDER_LINES    = DEF_BORDER_LINES;
    localparam int BORDER_CELLS    = DEF_BORDER_CELLS;
    localparam int LINE_GROUPS     = PIC_CELLS + 2 * BORDER_CELLS;
    localparam int RANDOM_REQUESTS = 300;
    // The store clear after reset, which keeps in_ready low, is by far the
    // longest quiet stretch of a correct run.
    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int TAIL_CYCLES     = 64;

    typedef struct packed {
        logic        op;
        logic [12:0] addr;
        logic [7:0]  value;
        logic [7:0]  line_no;
        logic [2:0]  border;
    } request_t;

    typedef struct {
        logic [31:0] group;
        logic        last;
    } group_expect_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        opcode        = OP_WRITE;
    logic [12:0] byte_address  = '0;
    logic [7:0]  byte_value    = '0;
    logic [7:0]  line_number   = '0;
    logic [2:0]  border_colour = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [31:0] pixel_group;
    logic        last_group;

    request_t      pending_requests[$];
    group_expect_t expected_groups[$];
    request_t      current_req;

    // Shadow of the block's state, updated in acceptance order.
    logic [7:0] shadow_store [STORE_SIZE];
    logic [4:0] flash_phase;

    int  total_requests    = 0;
    int  accepted_requests = 0;
    int  error_count       = 0;
    int  idle_cycles       = 0;
    int  send_gap          = 0;
    int  recv_stall        = 0;
    bit  send_calm         = 1'b0;
    bit  recv_calm         = 1'b0;

    attribute_video_scanline #(
        .BORDER_LINES (BORDER_LINES),
        .BORDER_CELLS (BORDER_CELLS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .byte_address  (byte_address),
        .byte_value    (byte_value),
        .line_number   (line_number),
        .border_colour (border_colour),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_group   (pixel_group),
        .last_group    (last_group)
    );

    always #10 clk = ~clk;

    // Bitmap offset of byte x on picture row: the rows are interleaved as
    // third of the screen, then pixel row in cell, then character row.
    function automatic logic [12:0] pixel_offset(input logic [7:0] row, input int x);
        logic [4:0] col;
        col = x[4:0];
        return {row[7:6], row[2:0], row[5:3], col};
    endfunction

    function automatic logic [12:0] attr_offset(input logic [7:0] row, input int x);
        logic [4:0] col;
        col = x[4:0];
        return ATTR_BASE + {3'b000, row[7:3], col};
    endfunction

    // Render fields of a write are noise; the block must ignore them.
    function automatic request_t write_req(input logic [12:0] addr, input logic [7:0] value);
        request_t r;
        r.op      = OP_WRITE;
        r.addr    = addr;
        r.value   = value;
        r.line_no = 8'($urandom);
        r.border  = 3'($urandom);
        return r;
    endfunction

    // Likewise the write fields of a render.
    function automatic request_t render_req(input logic [7:0] line_no, input logic [2:0] border);
        request_t r;
        r.op      = OP_RENDER;
        r.addr    = 13'($urandom);
        r.value   = 8'($urandom);
        r.line_no = line_no;
        r.border  = border;
        return r;
    endfunction

    // Mostly no gap, sometimes a few cycles, rarely a long pause; none at
    // all while the side is in a calm stretch.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Applies one accepted request to the shadow state and queues the groups
    // that a render must produce.
    task automatic predict_request(input request_t req);
        logic          picture;
        logic          flash_on;
        logic [7:0]    row;
        logic [7:0]    bits;
        logic [7:0]    attr;
        logic [3:0]    ink;
        logic [3:0]    paper;
        logic [3:0]    swap;
        logic [31:0]   group;
        group_expect_t entry;
        if (req.op == OP_WRITE)
        begin
            // Offsets past the end of the store are dropped.
            if (req.addr < STORE_SIZE)
                shadow_store[req.addr] = req.value;
        end
        else
        begin
            // Line 0 starts a new frame and moves the flash counter on.
            if (req.line_no == 8'd0)
                flash_phase = flash_phase + 5'd1;
            flash_on = (flash_phase < 5'd16);
            picture  = (req.line_no >= BORDER_LINES) &&
                       (req.line_no < BORDER_LINES + PIC_LINES);
            row      = 8'(req.line_no - BORDER_LINES);
            for (int k = 0; k < LINE_GROUPS; k++)
            begin
                group = {8{1'b0, req.border}};
                if (picture && k >= BORDER_CELLS && k < BORDER_CELLS + PIC_CELLS)
                begin
                    bits  = shadow_store[pixel_offset(row, k - BORDER_CELLS)];
                    attr  = shadow_store[attr_offset(row, k - BORDER_CELLS)];
                    // Bright lifts both ink and paper into the upper eight.
                    ink   = {attr[6], attr[2:0]};
                    paper = {attr[6], attr[5:3]};
                    if (attr[7] && flash_on)
                    begin
                        swap  = ink;
                        ink   = paper;
                        paper = swap;
                    end
                    for (int p = 7; p >= 0; p--)
                        group = {group[27:0], bits[p] ? ink : paper};
                end
                entry.group = group;
                entry.last  = (k == LINE_GROUPS - 1);
                expected_groups.push_back(entry);
            end
        end
    endtask

    // Request driver: predicts each request as it is accepted, then presents
    // the next one after a random gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_request(current_req);
                accepted_requests = accepted_requests + 1;
            end
            if (!in_valid || in_ready)
            begin
                if ($urandom_range(0, 49) == 0)
                    send_calm = !send_calm;
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    current_req = pending_requests.pop_front();
                    opcode        <= current_req.op;
                    byte_address  <= current_req.addr;
                    byte_value    <= current_req.value;
                    line_number   <= current_req.line_no;
                    border_colour <= current_req.border;
                    in_valid      <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Group monitor: checks every delivered group against the oldest
    // prediction and stalls the output at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_groups.size() == 0)
                begin
                    $display("%0t: unexpected group: pixel_group %h last_group %b",
                             $time, pixel_group, last_group);
                    error_count = error_count + 1;
                end
                else
                begin
                    if (pixel_group !== expected_groups[0].group)
                    begin
                        $display("%0t: pixel_group expected %h actual %h",
                                 $time, expected_groups[0].group, pixel_group);
                        error_count = error_count + 1;
                    end
                    if (last_group !== expected_groups[0].last)
                    begin
                        $display("%0t: last_group expected %b actual %b",
                                 $time, expected_groups[0].last, last_group);
                        error_count = error_count + 1;
                    end
                    void'(expected_groups.pop_front());
                end
            end
            if ($urandom_range(0, 49) == 0)
                recv_calm = !recv_calm;
            if (recv_stall > 0)
            begin
                recv_stall = recv_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall = pick_gap(recv_calm);
            end
        end
    end

    // Watchdog: any handshake on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request or group moved for %0d cycles", $time, idle_cycles);
            $display("tb_attribute_video_scanline failed");
            $finish;
        end
    end

    initial
    begin
        int       row;
        int       count;
        int       pick;
        int       random_count;
        request_t r;

        for (int i = 0; i < STORE_SIZE; i++)
            shadow_store[i] = 8'h00;
        flash_phase = 5'd0;

        // Directed part. The first render sees the cleared store.
        pending_requests.push_back(render_req(8'(BORDER_LINES), 3'd7));
        pending_requests.push_back(write_req(13'd0, 8'hA5));
        // Flashing bright cell: ink 1, paper 2.
        pending_requests.push_back(write_req(ATTR_BASE, 8'hD1));
        pending_requests.push_back(write_req(13'd31, 8'hFF));
        pending_requests.push_back(write_req(ATTR_BASE + 13'd31, 8'h38));
        // Last bitmap byte and last attribute byte of the store.
        pending_requests.push_back(write_req(13'd6143, 8'h0F));
        pending_requests.push_back(write_req(13'd6911, 8'h7A));
        // Writes past the end of the store must change nothing.
        pending_requests.push_back(write_req(13'd6912, 8'hFF));
        pending_requests.push_back(write_req(13'd8191, 8'hFF));
        pending_requests.push_back(render_req(8'd0, 3'd0));
        pending_requests.push_back(render_req(8'(BORDER_LINES - 1), 3'd5));
        pending_requests.push_back(render_req(8'(BORDER_LINES), 3'd2));
        pending_requests.push_back(render_req(8'(BORDER_LINES + PIC_LINES - 1), 3'd3));
        pending_requests.push_back(render_req(8'(BORDER_LINES + PIC_LINES), 3'd6));
        pending_requests.push_back(render_req(8'd239, 3'd1));
        pending_requests.push_back(render_req(8'd240, 3'd4));
        pending_requests.push_back(render_req(8'd255, 3'd7));
        pending_requests.push_back(write_req(ATTR_BASE, 8'h47));
        pending_requests.push_back(render_req(8'(BORDER_LINES + 7), 3'd0));

        // Random part. Most of it writes bytes that one picture row uses and
        // then renders that row, often followed by a new frame so that the
        // flash counter runs through both phases. The rest is noise over
        // the full field ranges.
        random_count = 0;
        while (random_count < RANDOM_REQUESTS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                row   = $urandom_range(0, PIC_LINES - 1);
                count = $urandom_range(1, 6);
                for (int i = 0; i < count; i++)
                begin
                    if ($urandom_range(0, 2) == 0)
                        r = write_req(attr_offset(8'(row), $urandom_range(0, 31)),
                                      8'($urandom));
                    else
                        r = write_req(pixel_offset(8'(row), $urandom_range(0, 31)),
                                      8'($urandom));
                    pending_requests.push_back(r);
                end
                pending_requests.push_back(render_req(8'(row + BORDER_LINES),
                                                      3'($urandom)));
                random_count = random_count + count + 1;
                if ($urandom_range(0, 9) < 6)
                begin
                    pending_requests.push_back(render_req(8'd0, 3'($urandom)));
                    random_count = random_count + 1;
                end
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    r = write_req(13'($urandom_range(0, 8191)), 8'($urandom));
                else
                    r = render_req(8'($urandom_range(0, 255)), 3'($urandom));
                pending_requests.push_back(r);
                random_count = random_count + 1;
            end
        end
        total_requests = pending_requests.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Checks happen on the falling edge, after all rising-edge activity.
        do
            @(negedge clk);
        while (accepted_requests != total_requests || expected_groups.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("tb_attribute_video_scanline passed");
        else
            $display("tb_attribute_video_scanline failed");
        $finish;
    end

endmodule

`default_nettype wire
